>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Overlapped implication.
`define ASSERT_IMPL(label, pre, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (cons)) \
    else $error(msg);
// Non-overlapped implication: consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, pre, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_IMPL(label, pre, cons, msg)
`define ASSERT_NEXT(label, pre, cons, msg)
`endif

`endif

>>> sv/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants of the trial division prime test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdpt_pkg;

  // First divisor tried.
  localparam int unsigned FIRST_DIVISOR = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_JUDGE,
    ST_DONE_P,
    ST_DONE_N
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;         // capture candidate, restart divisor
    logic div_start;    // clear remainder, arm bit counter
    logic div_step;     // one restoring remainder step
    logic next_div;     // d += 1, d*d tracked incrementally
    logic result_load;  // write output register
    logic result_val;   // flag written on result_load
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic n_lt2;     // candidate is zero or one
    logic sq_gt_n;   // d*d > candidate
    logic div_last;  // current step is the last remainder step
    logic rem_zero;  // remainder is zero
    logic out_free;  // output register can take a result this cycle
  } status_t;

endpackage

>>> sv/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Sequencer: divisor loop and bit-serial remainder steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdpt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tdpt_pkg::status_t status_i,
  output tdpt_pkg::cmd_t    cmd_o
);
  import tdpt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q) inside
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.n_lt2) begin
          state_d = ST_DONE_N;
        end else if (status_i.sq_gt_n) begin
          state_d = ST_DONE_P;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_JUDGE;
      end
      ST_JUDGE: begin
        state_d = status_i.rem_zero ? ST_DONE_N : ST_CHECK;
      end
      ST_DONE_P, ST_DONE_N: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CHECK: begin
        cmd_o.div_start = !status_i.n_lt2 && !status_i.sq_gt_n;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_JUDGE: begin
        cmd_o.next_div = !status_i.rem_zero;
      end
      ST_DONE_P: begin
        cmd_o.result_load = status_i.out_free;
        cmd_o.result_val  = 1'b1;
      end
      ST_DONE_N: begin
        cmd_o.result_load = status_i.out_free;
        cmd_o.result_val  = 1'b0;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/tdpt_dp.sv
// ----------------------------------------------------------------------------
// tdpt_dp
// Datapath: candidate, divisor, divisor square, remainder unit, output reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdpt_dp #(
  parameter int unsigned NUM_WIDTH = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [NUM_WIDTH-1:0] candidate_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 prime_flag_o,
  input  tdpt_pkg::cmd_t       cmd_i,
  output tdpt_pkg::status_t    status_o
);
  import tdpt_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_WIDTH);

  logic [NUM_WIDTH-1:0] n_q, d_q, rem_q;
  logic [NUM_WIDTH:0]   sq_q;   // d*d, below 2^(NUM_WIDTH+1) while in use
  logic [CNT_W-1:0]     cnt_q;
  logic                 out_valid_q, flag_q;

  logic [NUM_WIDTH:0] rem_shift, d_ext, rem_diff;

  assign d_ext     = {1'b0, d_q};
  assign rem_shift = {rem_q, n_q[cnt_q]};
  assign rem_diff  = rem_shift - d_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q  <= candidate_i;
      d_q  <= NUM_WIDTH'(FIRST_DIVISOR);
      sq_q <= (NUM_WIDTH+1)'(FIRST_DIVISOR * FIRST_DIVISOR);
    end else if (cmd_i.next_div) begin
      d_q  <= d_q + NUM_WIDTH'(1);
      sq_q <= sq_q + {d_q, 1'b1};   // (d+1)^2 = d^2 + 2d + 1
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      cnt_q <= CNT_W'(NUM_WIDTH - 1);
    end else if (cmd_i.div_step) begin
      // restoring step, candidate bits MSB first
      rem_q <= (rem_shift >= d_ext) ? rem_diff[NUM_WIDTH-1:0] : rem_shift[NUM_WIDTH-1:0];
      cnt_q <= cnt_q - CNT_W'(1);
    end
    if (cmd_i.result_load) flag_q <= cmd_i.result_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign prime_flag_o = flag_q;

  assign status_o.n_lt2    = (n_q[NUM_WIDTH-1:1] == '0);
  assign status_o.sq_gt_n  = (sq_q > {1'b0, n_q});
  assign status_o.div_last = (cnt_q == '0);
  assign status_o.rem_zero = (rem_q == '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

>>> sv/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test of one unsigned candidate per transfer by trial division.
// ----------------------------------------------------------------------------
// Input channel: candidate_i with in_valid_i / in_ready_o. Output channel:
// prime_flag_o with out_valid_o / out_ready_i. A transfer happens on a clock
// edge where valid and ready are both high. Every candidate gives exactly
// one flag: 1 for a prime, 0 otherwise (zero and one give 0).
// One candidate is worked on at a time; in_ready_o is high only while idle.
// Divisors d = 2, 3, ... are tried until d*d exceeds the candidate or one
// divides it. Each divisor goes through one check of d*d, NUM_WIDTH
// restoring remainder steps (one candidate bit each) and one judge step.
// A prime near 2^31 needs about 46340 divisors. Zero, one, two and three
// finish after the first check, with no remainder step.
// The flag is held in an output register; when the receiver stalls the
// block waits at the end of the current item until that register is free.
// Reset (rst_ni, asynchronous, active low) empties the output register and
// returns the sequencer to idle; any item in progress is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trial_division_prime_test #(
  parameter int unsigned NUM_WIDTH = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [NUM_WIDTH-1:0] candidate_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 prime_flag_o
);
  import tdpt_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: divisor loop, remainder steps, result handoff.
  tdpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: operands, incremental square, bit-serial remainder, output reg.
  tdpt_dp #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .candidate_i  (candidate_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .prime_flag_o (prime_flag_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );

  // An accepted candidate is captured, and the block is busy next cycle.
  `ASSERT_IMPL(a_accept_loads, in_valid_i && in_ready_o, cmd.load, "transfer without load")
  `ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o,
               "ready after transfer")
  // A result never overwrites one the receiver has not taken.
  `ASSERT_IMPL(a_no_overwrite, cmd.result_load, !out_valid_o || out_ready_i,
               "result overwrite")
  // Remainder steps and divisor updates never overlap a new load.
  `ASSERT_ALWAYS(a_cmd_exclusive, $onehot0({cmd.load, cmd.div_start, cmd.div_step,
                 cmd.next_div, cmd.result_load}), "overlapping commands")

endmodule
